FILE: rtl/assert_macros.svh
// Assertion macros used by the core RTL file of the byte pattern search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BPMO_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define BPMO_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/bpmo_pkg.sv
// Shared types and constants of the byte pattern search block.
package bpmo_pkg;

	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 3;
	localparam int NEEDLE_WORDS   = 4;
	localparam int NEEDLE_BYTES   = 32;
	localparam int NEEDLE_LEN_W   = 6;
	// Effective length width: holds any register value and any window depth up to 127.
	localparam int LEN_W          = 7;
	localparam int GAP_W          = 6;
	localparam int RESULT_W       = 32;
	localparam int LOW_ENTROPY_MIN_LEN = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 3'd4;

	typedef logic [NEEDLE_WORDS-1:0][CFG_W-1:0] needle_words_t;

	typedef struct packed {
		logic       all_same;
		logic       low_entropy;
		logic [7:0] first_byte;
	} needle_mode_t;

endpackage

FILE: rtl/bpmo_needle_decode.sv
// Needle decode: effective length, match mode and the needle laid out against the window.
module bpmo_needle_decode #(
	parameter int MAX_NEEDLE_BYTES = 32
) (
	input  bpmo_pkg::needle_words_t                  needle_words,
	input  logic [bpmo_pkg::NEEDLE_LEN_W-1:0]        needle_length,
	output logic [bpmo_pkg::LEN_W-1:0]               eff_len,
	output bpmo_pkg::needle_mode_t                   mode,
	output logic [MAX_NEEDLE_BYTES-1:0][7:0]         rev_needle
);
	import bpmo_pkg::*;

	localparam int IDX_W = (MAX_NEEDLE_BYTES > 1) ? $clog2(MAX_NEEDLE_BYTES) : 1;

	logic [NEEDLE_BYTES-1:0][7:0]     stored;
	logic [MAX_NEEDLE_BYTES-1:0][7:0] ext;
	logic [LEN_W-1:0]                 len_ext;

	assign stored = needle_words;

	// Needle bytes past the stored words read as zero.
	for (genvar g = 0; g < MAX_NEEDLE_BYTES; g++) begin : g_ext
		if (g < NEEDLE_BYTES) begin : g_stored
			assign ext[g] = stored[g];
		end else begin : g_zero
			assign ext[g] = 8'h00;
		end
	end

	assign len_ext = LEN_W'(needle_length);
	assign eff_len = (len_ext > LEN_W'(MAX_NEEDLE_BYTES)) ? LEN_W'(MAX_NEEDLE_BYTES) : len_ext;

	// Window entry k (0 newest) must equal needle byte eff_len-1-k.
	always_comb begin
		logic [LEN_W-1:0] idx;
		idx = '0;
		for (int k = 0; k < MAX_NEEDLE_BYTES; k++) begin
			idx = eff_len - LEN_W'(1) - LEN_W'(k);
			if (LEN_W'(k) < eff_len) begin
				rev_needle[k] = ext[idx[IDX_W-1:0]];
			end else begin
				rev_needle[k] = 8'h00;
			end
		end
	end

	always_comb begin
		logic [7:0] first;
		logic [7:0] second;
		logic       same;
		logic       two_ok;
		first  = ext[0];
		second = ext[0];
		same   = (eff_len != '0);
		two_ok = 1'b1;
		// The second value is the lowest-indexed byte that differs from the first.
		for (int i = MAX_NEEDLE_BYTES - 1; i >= 0; i--) begin
			if (LEN_W'(i) < eff_len && ext[i] != first) begin
				second = ext[i];
			end
		end
		for (int i = 0; i < MAX_NEEDLE_BYTES; i++) begin
			if (LEN_W'(i) < eff_len) begin
				if (ext[i] != first) begin
					same = 1'b0;
				end
				if (ext[i] != first && ext[i] != second) begin
					two_ok = 1'b0;
				end
			end
		end
		mode.first_byte  = first;
		mode.all_same    = same;
		mode.low_entropy = !same && (eff_len >= LEN_W'(LOW_ENTROPY_MIN_LEN)) && two_ok;
	end

endmodule

FILE: rtl/byte_pattern_match_offsets_core.sv
// Streaming fixed-needle byte search: top level with window, suppression state and output stage.
// A byte accepted into the input register yields its match offset in the output register
// when it advances. Throughput: one byte per cycle while no result waits on out_ready; the input
// register can still take one new byte while a result waits for its transfer, and then stalls.
// The rate is set by the combinational window compare and the registered suppression update.
// Reset (arst_n low) clears the needle registers, the stream state except the window, and both valid flags.
`include "assert_macros.svh"

module byte_pattern_match_offsets_core #(
	parameter int MAX_NEEDLE_BYTES = 32,
	parameter int OFFSET_WIDTH     = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_write_en,
	input  logic [bpmo_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpmo_pkg::CFG_W-1:0]         cfg_data,
	// Byte input channel.
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         data_byte,
	input  logic                               end_of_buffer,
	// Match result channel.
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bpmo_pkg::RESULT_W-1:0]      match_offset
);
	import bpmo_pkg::*;

	// Configuration registers.
	needle_words_t           needle_words_q;
	logic [NEEDLE_LEN_W-1:0] needle_length_q;

	// Input stage: one accepted byte waiting to be processed.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	// Stream state. The window needs no reset: a match only looks at bytes of
	// the current buffer, which are always written before they are compared.
	logic [MAX_NEEDLE_BYTES-1:0][7:0] window_q;
	logic [OFFSET_WIDTH-1:0]          seen_q;
	logic [GAP_W-1:0]                 gap_q;
	logic                             hold_q;

	// Output register.
	logic                out_valid_q;
	logic [RESULT_W-1:0] offset_q;

	// Decoded needle.
	logic [LEN_W-1:0]                 eff_len;
	needle_mode_t                     mode;
	logic [MAX_NEEDLE_BYTES-1:0][7:0] rev_needle;

	// Datapath signals for the byte in the input stage.
	logic [MAX_NEEDLE_BYTES-1:0][7:0] window_next;
	logic                             cmp_ok;
	logic [LEN_W-1:0]                 len_m1;
	logic [OFFSET_WIDTH-1:0]          len_m1_ext;
	logic                             not_sat;
	logic                             hit;
	logic                             hold_mid;
	logic                             blocked;
	logic                             report;
	logic [OFFSET_WIDTH-1:0]          start_off;
	logic [63:0]                      start_off_wide;
	logic                             advance;

	// ------------------------------------------------------------------
	// Configuration writes. An index beyond the register list is ignored.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_words_q  <= '0;
			needle_length_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_NEEDLE_WORD_0: needle_words_q[0] <= cfg_data;
				CFG_NEEDLE_WORD_1: needle_words_q[1] <= cfg_data;
				CFG_NEEDLE_WORD_2: needle_words_q[2] <= cfg_data;
				CFG_NEEDLE_WORD_3: needle_words_q[3] <= cfg_data;
				CFG_NEEDLE_LENGTH: needle_length_q   <= cfg_data[NEEDLE_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// The mode and the reversed needle depend on configuration only, so they
	// settle while the block is idle and stay off the byte-to-byte path.
	bpmo_needle_decode #(
		.MAX_NEEDLE_BYTES(MAX_NEEDLE_BYTES)
	) u_decode (
		.needle_words (needle_words_q),
		.needle_length(needle_length_q),
		.eff_len      (eff_len),
		.mode         (mode),
		.rev_needle   (rev_needle)
	);

	// ------------------------------------------------------------------
	// Handshake. The input stage drains whenever the output register is free
	// or is being emptied by a transfer in the same cycle.
	// ------------------------------------------------------------------
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	// ------------------------------------------------------------------
	// Window compare. The new byte becomes entry 0; every entry below the
	// needle length is checked against its needle byte in parallel.
	// ------------------------------------------------------------------
	always_comb begin
		window_next[0] = byte_s1;
		for (int j = 1; j < MAX_NEEDLE_BYTES; j++) begin
			window_next[j] = window_q[j-1];
		end
	end

	always_comb begin
		cmp_ok = 1'b1;
		for (int k = 0; k < MAX_NEEDLE_BYTES; k++) begin
			if (LEN_W'(k) < eff_len && window_next[k] != rev_needle[k]) begin
				cmp_ok = 1'b0;
			end
		end
	end

	assign len_m1     = eff_len - LEN_W'(1);
	assign len_m1_ext = OFFSET_WIDTH'(len_m1);

	// Once the offset counter saturates, bytes still shift through the window
	// but no match is reported and the suppression state is frozen.
	assign not_sat = (seen_q != '1);

	// A match needs a nonzero length and a full needle's worth of bytes from
	// the current buffer.
	assign hit = (eff_len != '0) && (seen_q >= len_m1_ext) && cmp_ok;

	// Run suppression ends on the first byte that differs from the run value;
	// the no-overlap gap blocks every byte while it counts down.
	assign hold_mid = hold_q && (byte_s1 == mode.first_byte);
	assign blocked  = hold_mid || (gap_q != '0);
	assign report   = not_sat && hit && !blocked;

	assign start_off      = seen_q - len_m1_ext;
	assign start_off_wide = 64'(start_off);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			gap_q  <= '0;
			hold_q <= 1'b0;
		end else if (advance) begin
			if (eob_s1) begin
				// The final byte of a buffer returns the stream to its start.
				seen_q <= '0;
				gap_q  <= '0;
				hold_q <= 1'b0;
			end else if (not_sat) begin
				seen_q <= seen_q + OFFSET_WIDTH'(1);
				if (report && mode.all_same) begin
					hold_q <= 1'b1;
				end else begin
					hold_q <= hold_mid;
				end
				if (report && !mode.all_same && mode.low_entropy) begin
					gap_q <= len_m1[GAP_W-1:0];
				end else if (gap_q != '0) begin
					gap_q <= gap_q - GAP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			window_q <= window_next;
		end
	end

	// ------------------------------------------------------------------
	// Output register. A processed byte without a match leaves it untouched.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && report) begin
			offset_q <= start_off_wide[RESULT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign match_offset = offset_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`BPMO_NEVER(a_hold_and_gap, clk, arst_n, hold_q && (gap_q != '0), "run hold and overlap gap both active")
	`BPMO_NEVER(a_gap_range, clk, arst_n, LEN_W'(gap_q) >= LEN_W'(MAX_NEEDLE_BYTES), "overlap gap exceeds needle depth")
	`BPMO_ASSERT(a_eob_clears, clk, arst_n, advance && eob_s1 |=> (seen_q == '0) && (gap_q == '0) && !hold_q, "stream state not cleared after end of buffer")
	`BPMO_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> valid_s1 && out_valid_q && !out_ready, "input stalled without a blocked result")

endmodule
